>>> hdl/mpu_region_translate_core_assert.svh
// Assertion macros for the region translate core.
// Included by the top level; uses its clk and rst signals.
`ifndef MPU_REGION_TRANSLATE_CORE_ASSERT_SVH
`define MPU_REGION_TRANSLATE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/mrt_pkg.sv
// Shared types, constants and helpers of the region translate core.
// Used by mrt_cell and mpu_region_translate_core; depends on nothing.
package mrt_pkg;

  localparam int ENTRIES    = 64;
  localparam int ADDR_W     = 64;
  localparam int PAGE_SHIFT = 12;
  localparam int VPN_W      = ADDR_W - PAGE_SHIFT;
  localparam int IDX_W      = 6;
  localparam int PERM_W     = 6;
  localparam int SLOT_CMP_W = 9;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 240;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_XLATE = 1'b1;

  localparam logic REG_MPU_ENABLE = 1'b0;

  localparam logic [2:0] PERM_SR = 3'd0;
  localparam logic [2:0] PERM_SW = 3'd1;
  localparam logic [2:0] PERM_SX = 3'd2;
  localparam logic [2:0] PERM_UR = 3'd3;
  localparam logic [2:0] PERM_UW = 3'd4;
  localparam logic [2:0] PERM_UX = 3'd5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_DENIED  = 2'd2,
    ST_WRITTEN = 2'd3
  } status_t;

  // Input tdata layout, highest field first.
  typedef struct packed {
    logic [2:0]        pad;
    logic              override_security;
    logic              is_supervisor;
    logic              is_execute;
    logic              is_write;
    logic [ADDR_W-1:0] access_va;
    logic [PERM_W-1:0] entry_perms;
    logic [VPN_W-1:0]  entry_size_pages;
    logic [VPN_W-1:0]  entry_pa_page;
    logic [VPN_W-1:0]  entry_va_page;
    logic              entry_valid;
    logic [IDX_W-1:0]  entry_index;
  } in_data_t;

  typedef struct packed {
    logic              valid;
    logic [VPN_W-1:0]  va_page;
    logic [VPN_W-1:0]  pa_page;
    logic [VPN_W-1:0]  size_pages;
    logic [PERM_W-1:0] perms;
  } region_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] va;
    logic              is_write;
    logic              is_execute;
    logic              is_supervisor;
    logic              override_security;
  } req_t;

  // What travels from cell to cell: the search token and, once a region
  // has decided, the finished answer.
  typedef struct packed {
    logic              valid;
    logic              done;
    status_t           status;
    logic [ADDR_W-1:0] addr;
  } beat_t;

  function automatic logic [2:0] perm_select(input logic wr, input logic ex,
                                             input logic sup);
    logic [2:0] bit_idx;
    if (ex) begin
      bit_idx = sup ? PERM_SX : PERM_UX;
    end else if (wr) begin
      bit_idx = sup ? PERM_SW : PERM_UW;
    end else begin
      bit_idx = sup ? PERM_SR : PERM_UR;
    end
    return bit_idx;
  endfunction

endpackage

>>> hdl/mrt_cell.sv
// One region cell of the translate chain: holds one region and checks the
// passing search beat against it. Depends on mrt_pkg.
module mrt_cell
  import mrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       we,
  input  region_wr_t wr,
  input  req_t       req,
  input  beat_t      beat_in,
  output beat_t      beat_out
);

  logic              valid;
  logic [VPN_W-1:0]  va_base;
  logic [VPN_W-1:0]  delta;
  logic [VPN_W-1:0]  length;
  logic [PERM_W-1:0] perms;

  logic [VPN_W-1:0]  vpage;
  logic [VPN_W-1:0]  page_off;
  logic              hit;
  logic              perm_ok;
  logic [ADDR_W-1:0] phys;
  beat_t             beat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (we) begin
      valid <= wr.valid;
    end
  end

  // The page delta is kept instead of the physical base, so the output
  // address is one add on the incoming page number.
  always_ff @(posedge clk) begin
    if (we) begin
      va_base <= wr.va_page;
      delta   <= wr.pa_page - wr.va_page;
      length  <= wr.size_pages;
      perms   <= wr.perms;
    end
  end

  always_comb begin
    vpage    = req.va[ADDR_W-1:PAGE_SHIFT];
    page_off = vpage - va_base;
    hit      = valid && (vpage >= va_base) && (page_off < length);
    perm_ok  = req.override_security ||
               perms[perm_select(req.is_write, req.is_execute, req.is_supervisor)];
    phys     = {vpage + delta, req.va[PAGE_SHIFT-1:0]};

    beat_next = beat_in;
    if (beat_in.valid && !beat_in.done && hit) begin
      beat_next.done = 1'b1;
      if (perm_ok) begin
        beat_next.status = ST_OK;
        beat_next.addr   = phys;
      end else begin
        beat_next.status = ST_DENIED;
        beat_next.addr   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else if (adv) begin
      beat_out.valid <= beat_next.valid;
    end
    if (adv) begin
      beat_out.done   <= beat_next.done;
      beat_out.status <= beat_next.status;
      beat_out.addr   <= beat_next.addr;
    end
  end

endmodule

>>> hdl/mpu_region_translate_core.sv
// Top level of the region translate core: stream ports, APB register,
// a chain of ENTRIES region cells and the result register.
// Depends on mrt_pkg, mrt_cell and mpu_region_translate_core_assert.svh.
//
//   Port group   Dir  Beat contents
//   s_axis_*     in   tuser: func; tdata: entry write fields and access fields
//   m_axis_*     out  tuser: status; tdata: phys_addr
//   APB          in   mpu_enable at byte address 0
//
// An item enters a head register, then its beat walks the region chain one
// cell per cycle while the chain is not held; a new item is taken only once
// the previous one has left the chain for the result register.
// The first cell that matches settles the answer; later cells pass it on.
// Reset is synchronous; region valid bits clear at once, no clearing pass.
// A result waiting on m_axis_tready holds the chain in place.

`include "mpu_region_translate_core_assert.svh"

module mpu_region_translate_core
  import mrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata, from bit 0: entry_index(6), entry_valid(1), entry_va_page(52),
  // entry_pa_page(52), entry_size_pages(52), entry_perms(6), access_va(64),
  // is_write(1), is_execute(1), is_supervisor(1), override_security(1), zeros(3)
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: func(1)
  input  logic                  s_axis_tuser,
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: phys_addr(64)
  output logic [ADDR_W-1:0]     m_axis_tdata,
  // tuser: status(2)
  output logic [1:0]            m_axis_tuser
);

  in_data_t           in_data;
  logic               accept;
  logic               is_entry_write;
  logic               cfg_wr;
  logic               mpu_enable;
  logic               busy;
  logic               adv;
  req_t               req;
  beat_t              head_beat;
  beat_t              inject;
  region_wr_t         wr;
  beat_t              beats [ENTRIES+1];
  logic [ENTRIES-1:0] chain_valid;
  beat_t              tail;

  assign in_data        = in_data_t'(s_axis_tdata);
  assign s_axis_tready  = !busy;
  assign accept         = s_axis_tvalid && s_axis_tready;
  assign is_entry_write = (s_axis_tuser == FUNC_WRITE);

  // The chain moves whenever the result register can take what reaches
  // the end of it.
  assign adv = !m_axis_tvalid || m_axis_tready;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mpu_enable <= 1'b0;
    end else if (cfg_wr && (paddr[2] == REG_MPU_ENABLE)) begin
      mpu_enable <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MPU_ENABLE) begin
      prdata[0] = mpu_enable;
    end
  end

  // Entry writes, pass-through translations and the search all use the
  // same path. Anything already settled enters the chain marked done and
  // simply rides through it, which keeps results in order.
  always_comb begin
    inject.valid  = 1'b1;
    inject.done   = is_entry_write || !mpu_enable;
    inject.status = is_entry_write ? ST_WRITTEN : ST_OK;
    inject.addr   = is_entry_write ? '0 : in_data.access_va;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      head_beat.valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (tail.valid && adv) begin
        busy <= 1'b0;
      end
      if (accept) begin
        head_beat.valid <= 1'b1;
      end else if (adv) begin
        head_beat.valid <= 1'b0;
      end
      if (accept) begin
        head_beat.done   <= inject.done;
        head_beat.status <= inject.status;
        head_beat.addr   <= inject.addr;
      end
    end
  end

  // The request stays broadcast to every cell while its beat walks by.
  always_ff @(posedge clk) begin
    if (accept) begin
      req.va                  <= in_data.access_va;
      req.is_write            <= in_data.is_write;
      req.is_execute          <= in_data.is_execute;
      req.is_supervisor       <= in_data.is_supervisor;
      req.override_security   <= in_data.override_security;
    end
  end

  // Region load data, written straight into the addressed cell. No item is
  // in flight while a new one is accepted, so nothing reads it mid-search.
  always_comb begin
    wr.valid      = in_data.entry_valid;
    wr.va_page    = in_data.entry_va_page;
    wr.pa_page    = in_data.entry_pa_page;
    wr.size_pages = in_data.entry_size_pages;
    wr.perms      = in_data.entry_perms;
  end

  assign beats[0] = head_beat;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic cell_we;

    // Slots beyond the table match no cell, so such writes change nothing.
    assign cell_we = accept && is_entry_write &&
                     (SLOT_CMP_W'(in_data.entry_index) == SLOT_CMP_W'(i));

    mrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .we       (cell_we),
      .wr       (wr),
      .req      (req),
      .beat_in  (beats[i]),
      .beat_out (beats[i+1])
    );

    assign chain_valid[i] = beats[i+1].valid;
  end

  assign tail = beats[ENTRIES];

  // Result register. A search beat that left the chain unsettled found no
  // region.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid && adv) begin
      m_axis_tuser <= tail.done ? tail.status : ST_NOMATCH;
      m_axis_tdata <= tail.done ? tail.addr : '0;
    end
  end

  // At most one item lives in the head register and the chain together.
  `MRT_ASSERT_SAME(a_single_item, 1'b1, $onehot0({chain_valid, head_beat.valid}), "more than one item in the region chain")
  // An idle core has nothing in flight.
  `MRT_ASSERT_SAME(a_idle_empty, !busy, !head_beat.valid && (chain_valid == '0), "item in flight while the core reports idle")
  // An accepted item is in the head register on the next cycle.
  `MRT_ASSERT_NEXT(a_accept_head, accept, busy && head_beat.valid, "accepted item did not enter the chain")
  // Only a translated access carries an address.
  `MRT_ASSERT_SAME(a_zero_addr, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0, "nonzero address with a non-translated status")

endmodule

>>> sim/tb_mpu_region_translate_core.sv
// Self-checking testbench for mpu_region_translate_core: region table loads,
// translations and the mpu_enable register. Depends on mrt_pkg and the core.
// A directed table runs first, then random phases with varying back-pressure.
module tb_mpu_region_translate_core;
  import mrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 20000;
  localparam logic [CFG_ADDR_W-1:0] ENABLE_ADDR = CFG_ADDR_W'(4 * REG_MPU_ENABLE);

  typedef struct packed {
    status_t           st;
    logic [ADDR_W-1:0] pa;
  } xlat_res_t;

  typedef struct {
    logic      en;
    logic      fn;
    in_data_t  d;
    logic      pinned;
    xlat_res_t res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid, s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid, m_axis_tready;
  logic [ADDR_W-1:0]     m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  // Shadow copy of the region table and the enable register.
  logic              rg_valid [ENTRIES];
  logic [VPN_W-1:0]  rg_va    [ENTRIES];
  logic [VPN_W-1:0]  rg_pa    [ENTRIES];
  logic [VPN_W-1:0]  rg_len   [ENTRIES];
  logic [PERM_W-1:0] rg_perm  [ENTRIES];
  logic              mpu_on;

  xlat_res_t pending_results[$];
  dir_row_t  dir_rows[$];
  xlat_res_t pin_res;
  logic      pin_on;
  int        mismatch_cnt;
  int        quiet_cycles;
  int        src_idle_pct;
  int        rcv_stall_pct;

  mpu_region_translate_core dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VPN_W-1:0] rand_page();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[VPN_W-1:0];
  endfunction

  function automatic logic perm_granted(input logic [PERM_W-1:0] p, input logic wr,
                                        input logic ex, input logic sup);
    if (ex) begin
      return sup ? p[PERM_SX] : p[PERM_UX];
    end
    if (wr) begin
      return sup ? p[PERM_SW] : p[PERM_UW];
    end
    return sup ? p[PERM_SR] : p[PERM_UR];
  endfunction

  // Applies one accepted beat to the shadow table and returns its result.
  function automatic xlat_res_t translate_or_load(input in_data_t d, input logic fn);
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] off;
    if (fn == FUNC_WRITE) begin
      if (d.entry_index < ENTRIES) begin
        rg_valid[d.entry_index] = d.entry_valid;
        rg_va[d.entry_index]    = d.entry_va_page;
        rg_pa[d.entry_index]    = d.entry_pa_page;
        rg_len[d.entry_index]   = d.entry_size_pages;
        rg_perm[d.entry_index]  = d.entry_perms;
      end
      return '{ST_WRITTEN, '0};
    end
    if (!mpu_on) begin
      return '{ST_OK, d.access_va};
    end
    // The lowest-numbered matching region settles the answer, even a denial.
    for (int i = 0; i < ENTRIES; i++) begin
      if (rg_valid[i]) begin
        base = {rg_va[i], {PAGE_SHIFT{1'b0}}};
        span = {rg_len[i], {PAGE_SHIFT{1'b0}}};
        off  = d.access_va - base;
        if (d.access_va >= base && off < span) begin
          if (!d.override_security &&
              !perm_granted(rg_perm[i], d.is_write, d.is_execute, d.is_supervisor)) begin
            return '{ST_DENIED, '0};
          end
          return '{ST_OK, off + {rg_pa[i], {PAGE_SHIFT{1'b0}}}};
        end
      end
    end
    return '{ST_NOMATCH, '0};
  endfunction

  task automatic add_write_row(input logic en, input int idx, input logic vld,
                               input logic [VPN_W-1:0] va, input logic [VPN_W-1:0] pa,
                               input logic [VPN_W-1:0] len, input logic [PERM_W-1:0] perms);
    dir_row_t r;
    r.en                 = en;
    r.fn                 = FUNC_WRITE;
    r.d                  = '0;
    r.d.entry_index      = idx[IDX_W-1:0];
    r.d.entry_valid      = vld;
    r.d.entry_va_page    = va;
    r.d.entry_pa_page    = pa;
    r.d.entry_size_pages = len;
    r.d.entry_perms      = perms;
    r.pinned             = 1'b1;
    r.res                = '{ST_WRITTEN, '0};
    dir_rows.push_back(r);
  endtask

  task automatic add_xlate_row(input logic en, input logic [ADDR_W-1:0] va, input logic wr,
                               input logic ex, input logic sup, input logic ovr,
                               input logic pinned, input status_t st,
                               input logic [ADDR_W-1:0] pa);
    dir_row_t r;
    r.en                  = en;
    r.fn                  = FUNC_XLATE;
    r.d                   = '0;
    r.d.access_va         = va;
    r.d.is_write          = wr;
    r.d.is_execute        = ex;
    r.d.is_supervisor     = sup;
    r.d.override_security = ovr;
    r.pinned              = pinned;
    r.res                 = '{st, pa};
    dir_rows.push_back(r);
  endtask

  // Drives one beat. When pinned, the typed result replaces the prediction.
  task automatic push_item(input in_data_t d, input logic fn, input logic pinned,
                           input xlat_res_t res);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= fn;
    pin_on  = pinned;
    pin_res = res;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drops tvalid and waits until every outstanding result has been taken.
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_mpu_enable(input logic en);
    drain_results();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENABLE_ADDR;
    pwdata  <= CFG_DATA_W'(en);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mpu_on = en;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random beat aimed mostly at regions that are live in the shadow table.
  task automatic make_random_item(output in_data_t d, output logic fn);
    int          live[$];
    int          roll;
    int          k;
    logic [63:0] base;
    logic [63:0] span;
    d                     = '0;
    d.entry_index         = IDX_W'($urandom);
    d.entry_valid         = ($urandom_range(0, 99) < 85);
    d.entry_va_page       = ($urandom_range(0, 99) < 70) ? VPN_W'($urandom_range(0, 255))
                                                          : rand_page();
    d.entry_pa_page       = rand_page();
    d.entry_perms         = PERM_W'($urandom);
    d.access_va           = rand64();
    d.is_write            = $urandom_range(0, 1);
    d.is_execute          = $urandom_range(0, 1);
    d.is_supervisor       = $urandom_range(0, 1);
    d.override_security   = ($urandom_range(0, 99) < 20);
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      d.entry_size_pages = VPN_W'($urandom_range(1, 16));
    end else if (roll < 85) begin
      d.entry_size_pages = '0;
    end else if (roll < 97) begin
      d.entry_size_pages = VPN_W'($urandom_range(17, 4096));
    end else begin
      d.entry_size_pages = rand_page();
    end
    fn = ($urandom_range(0, 99) < 30) ? FUNC_WRITE : FUNC_XLATE;
    if (fn == FUNC_WRITE) begin
      return;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (rg_valid[i] && rg_len[i] != 0) live.push_back(i);
    end
    roll = $urandom_range(0, 99);
    if (live.size() != 0 && roll < 75) begin
      k    = live[$urandom_range(0, live.size() - 1)];
      base = {rg_va[k], {PAGE_SHIFT{1'b0}}};
      span = {rg_len[k], {PAGE_SHIFT{1'b0}}};
      if (roll < 60) begin
        d.access_va = base + (rand64() % span);
      end else begin
        // Region edges: just below, last byte, first byte past the end.
        case ($urandom_range(0, 2))
          0:       d.access_va = base - 1;
          1:       d.access_va = base + span - 1;
          default: d.access_va = base + span;
        endcase
      end
    end else if (roll < 88) begin
      d.access_va = {40'h0, 12'($urandom_range(0, 300)), 12'($urandom)};
    end
  endtask

  // Input monitor: every accepted beat updates the shadow state.
  always @(posedge clk) begin
    xlat_res_t res;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      res = translate_or_load(in_data_t'(s_axis_tdata), s_axis_tuser);
      pending_results.push_back(pin_on ? pin_res : res);
    end
  end

  // Output checker against the oldest outstanding result.
  always @(posedge clk) begin
    xlat_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d addr %h", $time,
                 m_axis_tuser, m_axis_tdata);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== 2'(want.st)) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, m_axis_tuser);
          mismatch_cnt++;
        end
        if (m_axis_tdata !== want.pa) begin
          $display("%0t: phys_addr expected %h actual %h", $time, want.pa, m_axis_tdata);
          mismatch_cnt++;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  // Watchdog on cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_data_t d;
    logic     fn;
    int       phase_src [4] = '{0, 66, 0, 23};
    int       phase_rcv [4] = '{0, 0, 66, 23};
    logic     phase_en  [4] = '{1'b1, 1'b0, 1'b1, 1'b1};
    int       phase_cnt [4] = '{240, 100, 230, 230};
    logic [VPN_W-1:0]  ones52;
    logic [ADDR_W-1:0] ones64;

    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_WRITE;
    m_axis_tready = 1'b0;
    pin_on        = 1'b0;
    pin_res       = '{ST_OK, '0};
    mismatch_cnt  = 0;
    quiet_cycles  = 0;
    src_idle_pct  = 0;
    rcv_stall_pct = 0;
    mpu_on        = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      rg_valid[i] = 1'b0;
      rg_va[i]    = '0;
      rg_pa[i]    = '0;
      rg_len[i]   = '0;
      rg_perm[i]  = '0;
    end
    ones52 = '1;
    ones64 = '1;

    // Pass-through with the MPU off, then the region cases with it on, then pass-through again.
    add_xlate_row(0, '0, 0, 0, 0, 0, 1, ST_OK, '0);
    add_xlate_row(0, ones64, 1, 1, 1, 1, 1, ST_OK, ones64);
    add_xlate_row(1, 64'h1234, 0, 0, 0, 0, 1, ST_NOMATCH, '0);
    add_write_row(1, 0, 1, 'h10, 'h800, 2, 6'b001001);
    add_xlate_row(1, 64'h10abc, 0, 0, 1, 0, 0, ST_OK, '0);
    add_xlate_row(1, 64'h11fff, 0, 0, 0, 0, 0, ST_OK, '0);
    add_xlate_row(1, 64'h12000, 0, 0, 0, 0, 0, ST_OK, '0);
    add_xlate_row(1, 64'hffff, 0, 0, 1, 0, 0, ST_OK, '0);
    add_xlate_row(1, 64'h10800, 1, 0, 1, 0, 1, ST_DENIED, '0);
    // Execute takes precedence over write when both are set.
    add_xlate_row(1, 64'h10800, 1, 1, 0, 0, 1, ST_DENIED, '0);
    add_xlate_row(1, 64'h10800, 1, 1, 0, 1, 0, ST_OK, '0);
    // An overlapping region with every permission must not rescue a denial.
    add_write_row(1, 1, 1, 'h10, 'h900, 8, 6'h3f);
    add_xlate_row(1, 64'h10800, 1, 0, 1, 0, 1, ST_DENIED, '0);
    add_write_row(1, 2, 1, 'h20, 'h5, 0, 6'h3f);
    add_xlate_row(1, 64'h20000, 0, 0, 1, 0, 1, ST_NOMATCH, '0);
    add_write_row(1, ENTRIES - 1, 1, ones52, ones52, 1, 6'h3f);
    add_xlate_row(1, ones64, 0, 1, 0, 0, 0, ST_OK, '0);
    // The physical base near the top of memory makes the sum wrap.
    add_write_row(1, 3, 1, 'h40, ones52, 4, 6'b010000);
    add_xlate_row(1, 64'h41abc, 1, 0, 0, 0, 0, ST_OK, '0);
    add_write_row(1, 4, 1, '0, 'h77, ones52, 6'b100100);
    add_xlate_row(1, 64'hffff_ffff_ffff_e123, 0, 1, 1, 0, 0, ST_OK, '0);
    add_write_row(1, 4, 0, '0, '0, '0, '0);
    add_write_row(1, 0, 0, '0, '0, '0, '0);
    add_xlate_row(1, 64'h10800, 1, 0, 1, 0, 0, ST_OK, '0);
    add_xlate_row(0, 64'h10800, 1, 0, 1, 0, 1, ST_OK, 64'h10800);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].en != mpu_on) set_mpu_enable(dir_rows[i].en);
      push_item(dir_rows[i].d, dir_rows[i].fn, dir_rows[i].pinned, dir_rows[i].res);
    end

    for (int p = 0; p < 4; p++) begin
      set_mpu_enable(phase_en[p]);
      src_idle_pct  = phase_src[p];
      rcv_stall_pct = phase_rcv[p];
      for (int n = 0; n < phase_cnt[p]; n++) begin
        // Halfway through each phase the sender holds off until all is drained.
        if (n == phase_cnt[p] / 2) drain_results();
        make_random_item(d, fn);
        push_item(d, fn, 1'b0, '{ST_OK, '0});
      end
    end

    drain_results();
    repeat (ENTRIES + 8) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
